>>> rtl/u8u16_pkg.sv
// u8u16_pkg: shared types and constants of the utf-8 to utf-16 decoder
// used by every module under rtl; depends on nothing
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int KIND_W  = 2;
    localparam int LEAD_W  = 4;
    localparam int MID_W   = 6;

    // largest code unit count, where the count saturates
    localparam logic [UNIT_W-1:0] COUNT_MAX = {UNIT_W{1'b1}};

    // decoder phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SEQ     = 2'd1,
        PH_DISCARD = 2'd2
    } t_phase;

    // result kind
    typedef enum logic [KIND_W-1:0] {
        KIND_UNIT  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // one result from the decode logic
    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] code_unit;
        t_kind             kind;
        logic [UNIT_W-1:0] unit_count;
    } t_result;

endpackage

>>> rtl/u8u16_in_reg.sv
// u8u16_in_reg: input register stage holding one byte transaction
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_in_reg
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_advance,
    output logic              o_stage_valid,
    output logic [BYTE_W-1:0] o_stage_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_load;

    // stage is free when empty or being drained this cycle
    assign o_in_ready = !r_valid || i_advance;
    assign w_load     = i_in_valid && o_in_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // byte payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_in_byte;
        end
    end

    assign o_stage_valid = r_valid;
    assign o_stage_byte  = r_byte;

endmodule

>>> rtl/u8u16_decode.sv
// u8u16_decode: sequence state and per-byte decode logic
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    t_phase            r_phase, n_phase;
    logic [LEAD_W-1:0] r_lead, n_lead;
    logic [MID_W-1:0]  r_middle, n_middle;
    logic              r_two_more, n_two_more;
    logic [UNIT_W-1:0] r_emitted, n_emitted;
    logic [UNIT_W-1:0] w_emitted_inc;
    logic              w_is_nul;
    logic              w_is_cont;

    assign w_is_nul      = (i_byte == '0);
    assign w_is_cont     = (i_byte[7:6] == 2'b10);
    assign w_emitted_inc = (r_emitted == COUNT_MAX) ? r_emitted : r_emitted + 1'b1;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_lead     = r_lead;
        n_middle   = r_middle;
        n_two_more = r_two_more;
        n_emitted  = r_emitted;
        if (i_step) begin
            unique case (r_phase)
                PH_DISCARD: begin
                    if (w_is_nul) begin
                        n_phase   = PH_IDLE;
                        n_emitted = '0;
                    end
                end
                PH_SEQ: begin
                    if (w_is_nul) begin
                        n_phase    = PH_IDLE;
                        n_two_more = 1'b0;
                        n_emitted  = '0;
                    end else if (!w_is_cont) begin
                        n_phase    = PH_DISCARD;
                        n_two_more = 1'b0;
                    end else if (r_two_more) begin
                        n_middle   = i_byte[MID_W-1:0];
                        n_two_more = 1'b0;
                    end else begin
                        n_phase   = PH_IDLE;
                        n_emitted = w_emitted_inc;
                    end
                end
                default: begin
                    // idle, expecting a lead byte
                    if (w_is_nul) begin
                        n_phase   = PH_IDLE;
                        n_emitted = '0;
                    end else if (!i_byte[7]) begin
                        n_phase   = PH_IDLE;
                        n_emitted = w_emitted_inc;
                    end else if (i_byte[7:5] == 3'b110) begin
                        n_phase    = PH_SEQ;
                        n_lead     = '0;
                        n_middle   = {1'b0, i_byte[4:0]};
                        n_two_more = 1'b0;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        n_phase    = PH_SEQ;
                        n_lead     = i_byte[LEAD_W-1:0];
                        n_middle   = '0;
                        n_two_more = 1'b1;
                    end else begin
                        n_phase = PH_DISCARD;
                    end
                end
            endcase
        end
    end

    // result for the byte in the stage
    always_comb begin
        o_res            = '0;
        o_res.kind       = KIND_UNIT;
        unique case (r_phase)
            PH_DISCARD: begin
                o_res.valid = 1'b0;
            end
            PH_SEQ: begin
                if (w_is_nul || !w_is_cont) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                end else if (!r_two_more) begin
                    o_res.valid     = 1'b1;
                    o_res.code_unit = {r_lead, r_middle, i_byte[5:0]};
                end
            end
            default: begin
                if (w_is_nul) begin
                    o_res.valid      = 1'b1;
                    o_res.kind       = KIND_END;
                    o_res.unit_count = r_emitted;
                end else if (!i_byte[7]) begin
                    o_res.valid     = 1'b1;
                    o_res.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, i_byte};
                end else if (i_byte[7:5] != 3'b110 && i_byte[7:4] != 4'b1110) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_two_more <= 1'b0;
            r_emitted  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_two_more <= n_two_more;
            r_emitted  <= n_emitted;
        end
    end

    // partial code unit bits
    always_ff @(posedge i_clk) begin
        r_lead   <= n_lead;
        r_middle <= n_middle;
    end

    // a pending middle byte only exists inside a sequence
    a_two_more_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_two_more |-> r_phase == PH_SEQ)
        else $error("two_more set outside a sequence");

    // nothing is reported while discarding
    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DISCARD |-> !o_res.valid)
        else $error("result while discarding");

    // end of string clears the count
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid && o_res.kind == KIND_END |=> r_emitted == '0)
        else $error("count not cleared after end of string");

    // each code unit bumps the count until it saturates
    a_count_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.valid && o_res.kind == KIND_UNIT && r_emitted != COUNT_MAX
        |=> r_emitted == $past(r_emitted) + 1'b1)
        else $error("count not incremented for code unit");

endmodule

>>> rtl/u8u16_out_reg.sv
// u8u16_out_reg: result register feeding the output channel
// depends on u8u16_pkg
`timescale 1ns / 1ps

module u8u16_out_reg
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_stage_valid,
    input  t_result           i_res,
    output logic              o_advance,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [UNIT_W-1:0] o_code_unit,
    output logic [KIND_W-1:0] o_kind,
    output logic [UNIT_W-1:0] o_unit_count
);

    logic              r_valid;
    logic [UNIT_W-1:0] r_code_unit;
    t_kind             r_kind;
    logic [UNIT_W-1:0] r_unit_count;

    // the stage moves on when the result register is empty or being taken
    assign o_advance = i_stage_valid && (!r_valid || i_out_ready);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res.valid;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_advance && i_res.valid) begin
            r_code_unit  <= i_res.code_unit;
            r_kind       <= i_res.kind;
            r_unit_count <= i_res.unit_count;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_code_unit  = r_code_unit;
    assign o_kind       = r_kind;
    assign o_unit_count = r_unit_count;

endmodule

>>> rtl/utf8_to_utf16_decoder.sv
// utf8_to_utf16_decoder: top level of the utf-8 to utf-16 decoder
// depends on u8u16_pkg, u8u16_in_reg, u8u16_decode, u8u16_out_reg
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) takes one byte of a
//   NUL-terminated utf-8 string per transaction. Output channel
//   (o_out_valid / i_out_ready) returns at most one result per byte:
//   o_kind KIND_UNIT carries o_code_unit, KIND_END carries o_unit_count
//   (saturating at 65535), KIND_ERROR marks malformed input, after which
//   bytes are dropped silently up to the string's NUL.
//   Throughput: one byte per cycle while the output does not stall, set by the
//   single decode pass between the input register and the result register.
//   Path: an accepted byte is held in the input register, then its result is
//   captured in the result register when that register is free or being read.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   decoder to idle with a zero unit count.
//   When the receiver stalls, the result register holds its transaction;
//   one more byte is still taken into the input register, after which
//   o_in_ready drops until the output drains.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [UNIT_W-1:0] o_code_unit,
    output logic [KIND_W-1:0] o_kind,
    output logic [UNIT_W-1:0] o_unit_count
);

    logic              w_advance;
    logic              w_stage_valid;
    logic [BYTE_W-1:0] w_stage_byte;
    t_result           w_res;

    // input register
    u8u16_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_advance     (w_advance),
        .o_stage_valid (w_stage_valid),
        .o_stage_byte  (w_stage_byte)
    );

    // decode and sequence state
    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (w_stage_byte),
        .o_res   (w_res)
    );

    // result register
    u8u16_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage_valid (w_stage_valid),
        .i_res         (w_res),
        .o_advance     (w_advance),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_code_unit   (o_code_unit),
        .o_kind        (o_kind),
        .o_unit_count  (o_unit_count)
    );

endmodule
